FILE: design/spk_pkg.sv
// Shared types and constants for the spectral peak top-N picker.
package spk_pkg;

    localparam int NUM_PEAKS_DEF = 5;
    localparam int MAX_BINS_DEF  = 1024;

    localparam int BIN_W     = 10;
    localparam int LEVEL_W   = 16;
    localparam int RUN_LEN_W = 11;
    localparam int CFG_IDX_W = 1;

    localparam logic [RUN_LEN_W-1:0] RUN_LEN_MAX = '1;

    localparam logic [BIN_W-1:0] LOW_BIN_RST  = 10'd8;
    localparam logic [BIN_W-1:0] HIGH_BIN_RST = 10'd120;

    localparam logic [CFG_IDX_W-1:0] CFG_LOW_BIN  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_BIN = 1'b1;

    typedef struct packed {
        logic signed [LEVEL_W-1:0] level;
        logic                      frame_end;
    } bin_item_t;

    typedef struct packed {
        logic [BIN_W-1:0] peak_bin;
        logic             peak_valid;
        logic             last_slot;
    } slot_item_t;

    typedef struct packed {
        logic step;
        logic flush;
        logic sort_pass;
        logic sort_odd;
        logic load;
        logic last;
        logic clear;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_stat_t;

endpackage

FILE: design/spk_ctrl.sv
// Controller state machine: scan, final run flush, bin sort and slot emission.
module spk_ctrl #(
    parameter int NUM_PEAKS = spk_pkg::NUM_PEAKS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              bin_valid,
    input  logic              frame_end,
    output logic              bin_stall,
    output spk_pkg::dp_cmd_t  cmd,
    input  spk_pkg::dp_stat_t stat
);

    localparam int SLOT_W = (NUM_PEAKS > 1) ? $clog2(NUM_PEAKS) : 1;
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(NUM_PEAKS - 1);

    typedef enum logic [1:0] {
        ST_RUN,
        ST_FLUSH,
        ST_SORT,
        ST_EMIT
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [SLOT_W-1:0] idx_reg;
    logic [SLOT_W-1:0] idx_next;

    always_comb
    begin
        cmd           = '0;
        cmd.step      = (state_reg == ST_RUN) && bin_valid;
        cmd.flush     = (state_reg == ST_FLUSH);
        cmd.sort_pass = (state_reg == ST_SORT);
        cmd.sort_odd  = idx_reg[0];
        cmd.load      = (state_reg == ST_EMIT) && stat.out_free;
        cmd.last      = (idx_reg == SLOT_LAST);
        cmd.clear     = cmd.load && cmd.last;
        bin_stall     = (state_reg != ST_RUN);
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        case (state_reg)
            ST_RUN:
            begin
                if (cmd.step && frame_end)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                state_next = ST_SORT;
                idx_next   = '0;
            end
            ST_SORT:
            begin
                if (idx_reg == SLOT_LAST)
                begin
                    state_next = ST_EMIT;
                    idx_next   = '0;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (cmd.load)
                begin
                    if (cmd.last)
                    begin
                        state_next = ST_RUN;
                        idx_next   = '0;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_RUN;
                idx_next   = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RUN;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

FILE: design/spk_dpath.sv
// Datapath: bin counter, run tracking, top-N list, bin sort and output register.
module spk_dpath #(
    parameter int NUM_PEAKS = spk_pkg::NUM_PEAKS_DEF,
    parameter int MAX_BINS  = spk_pkg::MAX_BINS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  spk_pkg::dp_cmd_t                  cmd,
    output spk_pkg::dp_stat_t                 stat,
    input  spk_pkg::bin_item_t                bin_data,
    input  logic                              cfg_valid,
    input  logic [spk_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [spk_pkg::BIN_W-1:0]         cfg_data,
    output logic                              slot_valid,
    input  logic                              slot_stall,
    output spk_pkg::slot_item_t               slot_data
);

    localparam int BW    = spk_pkg::BIN_W;
    localparam int LW    = spk_pkg::LEVEL_W;
    localparam int RW    = spk_pkg::RUN_LEN_W;
    localparam int CW    = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int KW    = (CW > BW) ? CW : BW;
    localparam int PW    = ((CW > RW) ? CW : RW) + 1;
    localparam int CNT_W = $clog2(NUM_PEAKS + 1);
    localparam logic [CW-1:0]    CNT_LAST = CW'(MAX_BINS - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(NUM_PEAKS);

    logic [BW-1:0]          low_bin_reg;
    logic [BW-1:0]          low_bin_next;
    logic [BW-1:0]          high_bin_reg;
    logic [BW-1:0]          high_bin_next;
    logic [CW-1:0]          bin_cnt_reg;
    logic [CW-1:0]          bin_cnt_next;
    logic signed [LW-1:0]   prev_reg;
    logic signed [LW-1:0]   prev_next;
    logic                   run_act_reg;
    logic                   run_act_next;
    logic [CW-1:0]          run_start_reg;
    logic [CW-1:0]          run_start_next;
    logic [RW-1:0]          run_len_reg;
    logic [RW-1:0]          run_len_next;
    logic signed [LW-1:0]   run_lvl_reg;
    logic signed [LW-1:0]   run_lvl_next;
    logic signed [LW-1:0]   best_lv_reg [NUM_PEAKS];
    logic signed [LW-1:0]   best_lv_next [NUM_PEAKS];
    logic [BW-1:0]          best_bin_reg [NUM_PEAKS];
    logic [BW-1:0]          best_bin_next [NUM_PEAKS];
    logic [CNT_W-1:0]       best_cnt_reg;
    logic [CNT_W-1:0]       best_cnt_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    spk_pkg::slot_item_t    out_reg;
    spk_pkg::slot_item_t    out_next;

    logic signed [LW-1:0]   lev;
    logic [KW-1:0]          b_ext;
    logic                   below_high;
    logic                   at_low;
    logic                   above_low;
    logic                   close_run;
    logic [PW-1:0]          pos_sum;
    logic [BW-1:0]          pos_bin;
    logic [NUM_PEAKS-1:0]   lt;
    logic [NUM_PEAKS-1:0]   lt_prev;
    logic [NUM_PEAKS-1:0]   slot_used;

    assign lev        = bin_data.level;
    assign b_ext      = KW'(bin_cnt_reg);
    assign below_high = b_ext < KW'(high_bin_reg);
    assign at_low     = b_ext == KW'(low_bin_reg);
    assign above_low  = b_ext >= KW'(low_bin_reg);
    assign pos_sum    = PW'(run_start_reg) + PW'(run_len_reg >> 1);
    assign pos_bin    = pos_sum[BW-1:0];

    always_comb
    begin
        low_bin_next  = low_bin_reg;
        high_bin_next = high_bin_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                spk_pkg::CFG_LOW_BIN:  low_bin_next  = cfg_data;
                spk_pkg::CFG_HIGH_BIN: high_bin_next = cfg_data;
                default:               low_bin_next  = low_bin_reg;
            endcase
        end
    end

    always_comb
    begin
        bin_cnt_next   = bin_cnt_reg;
        prev_next      = prev_reg;
        run_act_next   = run_act_reg;
        run_start_next = run_start_reg;
        run_len_next   = run_len_reg;
        run_lvl_next   = run_lvl_reg;
        close_run      = 1'b0;
        if (cmd.clear)
        begin
            bin_cnt_next   = '0;
            prev_next      = '0;
            run_act_next   = 1'b0;
            run_start_next = '0;
            run_len_next   = '0;
            run_lvl_next   = '0;
        end
        else if (cmd.step)
        begin
            if (run_act_reg)
            begin
                if (lev == run_lvl_reg && below_high)
                begin
                    if (run_len_reg != spk_pkg::RUN_LEN_MAX)
                    begin
                        run_len_next = run_len_reg + 1'b1;
                    end
                end
                else if (lev > run_lvl_reg)
                begin
                    run_act_next = 1'b0;
                end
                else
                begin
                    close_run    = 1'b1;
                    run_act_next = 1'b0;
                end
            end
            if (!run_act_next && above_low && below_high && (at_low || lev > prev_reg))
            begin
                run_act_next   = 1'b1;
                run_start_next = bin_cnt_reg;
                run_len_next   = RW'(1);
                run_lvl_next   = lev;
            end
            prev_next    = lev;
            bin_cnt_next = (bin_cnt_reg == CNT_LAST) ? '0 : bin_cnt_reg + 1'b1;
        end
        else if (cmd.flush)
        begin
            close_run    = run_act_reg;
            run_act_next = 1'b0;
        end
    end

    always_comb
    begin
        for (int j = 0; j < NUM_PEAKS; j++)
        begin
            lt[j]        = best_lv_reg[j] < run_lvl_reg;
            slot_used[j] = CNT_W'(j) < best_cnt_reg;
        end
        lt_prev = lt << 1;
    end

    always_comb
    begin
        best_lv_next  = best_lv_reg;
        best_bin_next = best_bin_reg;
        best_cnt_next = best_cnt_reg;
        if (cmd.clear)
        begin
            for (int j = 0; j < NUM_PEAKS; j++)
            begin
                best_lv_next[j]  = '0;
                best_bin_next[j] = '0;
            end
            best_cnt_next = '0;
        end
        else if (close_run)
        begin
            if (lt[0])
            begin
                best_lv_next[0]  = run_lvl_reg;
                best_bin_next[0] = pos_bin;
            end
            for (int j = 1; j < NUM_PEAKS; j++)
            begin
                if (lt[j])
                begin
                    if (lt_prev[j])
                    begin
                        best_lv_next[j]  = best_lv_reg[j-1];
                        best_bin_next[j] = best_bin_reg[j-1];
                    end
                    else
                    begin
                        best_lv_next[j]  = run_lvl_reg;
                        best_bin_next[j] = pos_bin;
                    end
                end
            end
            if (lt[NUM_PEAKS-1] && best_cnt_reg != CNT_FULL)
            begin
                best_cnt_next = best_cnt_reg + 1'b1;
            end
        end
        else if (cmd.sort_pass)
        begin
            for (int j = 0; j < NUM_PEAKS - 1; j++)
            begin
                if ((j % 2 == 1) == cmd.sort_odd && slot_used[j+1] &&
                    best_bin_reg[j] > best_bin_reg[j+1])
                begin
                    best_bin_next[j]   = best_bin_reg[j+1];
                    best_bin_next[j+1] = best_bin_reg[j];
                end
            end
        end
        else if (cmd.load)
        begin
            for (int j = 0; j < NUM_PEAKS - 1; j++)
            begin
                best_bin_next[j] = best_bin_reg[j+1];
            end
            best_bin_next[NUM_PEAKS-1] = '0;
            if (best_cnt_reg != '0)
            begin
                best_cnt_next = best_cnt_reg - 1'b1;
            end
        end
    end

    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg && slot_stall;
        if (cmd.load)
        begin
            out_valid_next      = 1'b1;
            out_next.peak_valid = (best_cnt_reg != '0);
            out_next.peak_bin   = (best_cnt_reg != '0) ? best_bin_reg[0] : '0;
            out_next.last_slot  = cmd.last;
        end
    end

    assign stat.out_free = !out_valid_reg || !slot_stall;
    assign slot_valid    = out_valid_reg;
    assign slot_data     = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_bin_reg   <= spk_pkg::LOW_BIN_RST;
            high_bin_reg  <= spk_pkg::HIGH_BIN_RST;
            bin_cnt_reg   <= '0;
            prev_reg      <= '0;
            run_act_reg   <= 1'b0;
            run_start_reg <= '0;
            run_len_reg   <= '0;
            run_lvl_reg   <= '0;
            for (int j = 0; j < NUM_PEAKS; j++)
            begin
                best_lv_reg[j]  <= '0;
                best_bin_reg[j] <= '0;
            end
            best_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            low_bin_reg   <= low_bin_next;
            high_bin_reg  <= high_bin_next;
            bin_cnt_reg   <= bin_cnt_next;
            prev_reg      <= prev_next;
            run_act_reg   <= run_act_next;
            run_start_reg <= run_start_next;
            run_len_reg   <= run_len_next;
            run_lvl_reg   <= run_lvl_next;
            best_lv_reg   <= best_lv_next;
            best_bin_reg  <= best_bin_next;
            best_cnt_reg  <= best_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

endmodule

FILE: design/spectral_peak_top_n_picker_core.sv
// Top level of the spectral peak top-N picker: controller plus datapath.
//
//  channel  direction  handshake              request
//  bin      in         bin_valid / bin_stall  bin_data  (level, frame_end)
//  slot     out        slot_valid / slot_stall slot_data (peak_bin, peak_valid, last_slot)
//  cfg      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  A bin request without frame_end leaves bin_stall low; bins stream back to back.
//  A frame_end request holds bin_stall high through three phases: a flush state
//  to close the open run, NUM_PEAKS odd-even sort passes over the list,
//  then NUM_PEAKS slot requests through the output register, paced by slot_stall.
//  rst_n clears all but slot_data asynchronously; low_bin, high_bin return to 8 and 120.
module spectral_peak_top_n_picker_core #(
    parameter int NUM_PEAKS = spk_pkg::NUM_PEAKS_DEF,
    parameter int MAX_BINS  = spk_pkg::MAX_BINS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          bin_valid,
    output logic                          bin_stall,
    input  spk_pkg::bin_item_t            bin_data,
    output logic                          slot_valid,
    input  logic                          slot_stall,
    output spk_pkg::slot_item_t           slot_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [spk_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [spk_pkg::BIN_W-1:0]     cfg_data
);

    spk_pkg::dp_cmd_t  cmd;
    spk_pkg::dp_stat_t stat;

    assign cfg_ready = 1'b1;

    spk_ctrl #(
        .NUM_PEAKS (NUM_PEAKS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .bin_valid (bin_valid),
        .frame_end (bin_data.frame_end),
        .bin_stall (bin_stall),
        .cmd       (cmd),
        .stat      (stat)
    );

    spk_dpath #(
        .NUM_PEAKS (NUM_PEAKS),
        .MAX_BINS  (MAX_BINS)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .bin_data   (bin_data),
        .cfg_valid  (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .slot_valid (slot_valid),
        .slot_stall (slot_stall),
        .slot_data  (slot_data)
    );

endmodule
